// File: hw/rtl/sfms_pkg.sv
// ----------------------------------------------------------------------------
// sfms_pkg
// Shared constants, types and helpers for the first-match substring search.
// ----------------------------------------------------------------------------
package sfms_pkg;

  localparam int unsigned          MAX_PATTERN_DEF = 64;
  localparam longint unsigned      MAX_TEXT_DEF    = 64'd65536;

  // kind carried in s_tuser
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic       load;       // write raw_byte into the addressed cell
    logic       search;     // advance the partial-match chain
    logic       clear;      // drop all partial matches
    logic       fold_case;  // fold ascii upper case before compare
    logic [7:0] raw_byte;   // pattern byte as received
    logic [7:0] cmp_byte;   // text byte, already folded
  } cell_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic en, input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (en && b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/sfms_cell.sv
// ----------------------------------------------------------------------------
// sfms_cell
// One pattern position: holds its byte and its partial-match bit, passes the
// bit on to the next cell each cycle that a text byte is searched.
// ----------------------------------------------------------------------------
module sfms_cell import sfms_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned LW  = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctrl_t    ctrl,
  input  logic [LW-1:0] wr_idx,
  input  logic [LW-1:0] len,
  input  logic          prev_pm,
  output logic          pm,
  output logic          end_hit
);

  logic [7:0] pat;
  logic       active;
  logic       pm_new;

  assign active  = LW'(IDX) < len;
  assign pm_new  = active && prev_pm && (fold_byte(ctrl.fold_case, pat) == ctrl.cmp_byte);
  // only the cell holding the final pattern byte can complete a match
  assign end_hit = pm_new && (len == LW'(IDX + 1));

  always_ff @(posedge clk) begin
    if (ctrl.load && wr_idx == LW'(IDX)) begin
      pat <= ctrl.raw_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pm <= 1'b0;
    end else if (ctrl.clear) begin
      pm <= 1'b0;
    end else if (ctrl.search) begin
      pm <= pm_new;
    end
  end

endmodule

// File: hw/rtl/substring_first_match_search_unit.sv
// A result appears on m_tdata in the cycle after the text byte that causes it.
// Throughput: one byte (pattern or text) per cycle while the output is not stalled; every cell compares
// its stored byte against the broadcast text byte in the same cycle.
// Only the single output register can stall the input side (s_tready follows m_tready).
// Reset: fold_case off, pattern empty, search state cleared; no clearing pass,
// pattern storage is only read below the loaded length.
// ----------------------------------------------------------------------------
// substring_first_match_search_unit
// Streams a pattern into a row of compare cells, then reports the first match
// of that pattern in the following text, or no match at the end of the text.
// ----------------------------------------------------------------------------
module substring_first_match_search_unit import sfms_pkg::*; #(
  parameter int unsigned     MAX_PATTERN = MAX_PATTERN_DEF,
  parameter longint unsigned MAX_TEXT    = MAX_TEXT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,   // [0] fold_case
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] byte_value
  input  logic        s_tuser,    // [0] cmd
  input  logic        s_tlast,    // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata     // [0] found, [16:1] match_position,
                                  // [17] pattern_invalid, [23:18] zero
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PW = $clog2(MAX_TEXT + 1);

  logic            fold_case;
  logic [LW-1:0]   pattern_length;
  logic            pattern_overflow;
  logic            pattern_restart;
  logic [PW-1:0]   text_position;
  logic            search_done;

  logic            out_found;
  logic [15:0]     out_position;
  logic            out_invalid;

  logic            acc;
  logic            is_load;
  logic            is_text;
  logic [LW-1:0]   wr_idx;
  logic            can_write;
  logic            step;
  logic            usable;
  logic            hit_now;
  logic            report;
  logic [PW-1:0]   start;
  cell_ctrl_t      ctrl;

  logic [MAX_PATTERN-1:0] pm;
  logic [MAX_PATTERN-1:0] end_hit;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign acc       = s_tvalid && s_tready;
  assign is_load   = acc && s_tuser == CMD_PATTERN;
  assign is_text   = acc && s_tuser == CMD_TEXT;

  // a finished pattern restarts at position zero
  assign wr_idx    = pattern_restart ? '0 : pattern_length;
  assign can_write = wr_idx < LW'(MAX_PATTERN);
  assign step      = !search_done && (text_position < PW'(MAX_TEXT));
  assign usable    = pattern_length != '0 && !pattern_overflow;

  always_comb begin
    ctrl.load      = is_load && can_write;
    ctrl.search    = is_text && step && usable;
    ctrl.clear     = (is_load && pattern_restart) || (is_text && s_tlast);
    ctrl.fold_case = fold_case;
    ctrl.raw_byte  = s_tdata;
    ctrl.cmp_byte  = fold_byte(fold_case, s_tdata);
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = pm[k-1];
    end
    sfms_cell #(
      .IDX (k),
      .LW  (LW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .wr_idx  (wr_idx),
      .len     (pattern_length),
      .prev_pm (prev),
      .pm      (pm[k]),
      .end_hit (end_hit[k])
    );
  end

  assign hit_now = ctrl.search && (|end_hit);
  assign report  = is_text && (hit_now || (s_tlast && !search_done));
  assign start   = PW'(text_position + PW'(1) - PW'(pattern_length));

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_case        <= 1'b0;
      pattern_length   <= '0;
      pattern_overflow <= 1'b0;
      pattern_restart  <= 1'b1;
      text_position    <= '0;
      search_done      <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fold_case <= cfg_data;
      end
      // hold until the transfer, reload on a new report
      m_tvalid <= report || (m_tvalid && !m_tready);
      if (is_load) begin
        if (pattern_restart) begin
          text_position <= '0;
          search_done   <= 1'b0;
        end
        if (can_write) begin
          pattern_length <= LW'(wr_idx + LW'(1));
        end
        pattern_overflow <= !can_write || (pattern_overflow && !pattern_restart);
        pattern_restart  <= s_tlast;
      end
      if (is_text) begin
        pattern_restart <= 1'b1;
        if (s_tlast) begin
          text_position <= '0;
          search_done   <= 1'b0;
        end else begin
          if (step) begin
            text_position <= PW'(text_position + PW'(1));
          end
          if (hit_now) begin
            search_done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      out_found    <= hit_now;
      out_position <= hit_now ? 16'(start) : 16'd0;
      out_invalid  <= hit_now ? 1'b0 : pattern_overflow;
    end
  end

  assign m_tdata = {6'd0, out_invalid, out_position, out_found};

`ifndef SYNTHESIS
  a_found_valid_pattern: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_found |-> !out_invalid)
    else $error("match reported together with invalid pattern");

  a_single_end_cell: assert property (@(posedge clk) disable iff (rst)
    $onehot0(end_hit))
    else $error("more than one cell completed a match");

  a_no_hit_after_done: assert property (@(posedge clk) disable iff (rst)
    search_done |-> !hit_now)
    else $error("second match reported in one text");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    pattern_overflow |-> pattern_length == LW'(MAX_PATTERN))
    else $error("overflow flagged below full pattern length");

  a_text_end_clears: assert property (@(posedge clk) disable iff (rst)
    is_text && s_tlast |=> text_position == '0 && !search_done && pm == '0)
    else $error("search state not cleared after end of text");
`endif

endmodule
